### sv/dsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsw_pkg: shared types, constants and control program
// Sizes of the dice sum datapath, op and branch codes, and the microcode ROM.
// ----------------------------------------------------------------------------
package dsw_pkg;

	localparam int MAX_DICE  = 32;
	localparam int MAX_FACES = 32;
	localparam int MAX_SUM   = 1024;

	localparam int COUNT_W   = 6;   // dice_count and face_count fields
	localparam int SUM_W     = 11;  // target_sum field and row addresses
	localparam int WAY_W     = 30;  // way_count field
	localparam int ROW_DEPTH = MAX_SUM + 1;

	localparam logic [WAY_W:0] WAY_MOD = 31'd1000000007;

	// datapath operations
	localparam logic [3:0] OP_NONE        = 4'd0;
	localparam logic [3:0] OP_LOAD        = 4'd1;
	localparam logic [3:0] OP_ROW_START   = 4'd2;
	localparam logic [3:0] OP_SUM_START   = 4'd3;
	localparam logic [3:0] OP_READ_TAP    = 4'd4;
	localparam logic [3:0] OP_WRITE       = 4'd5;
	localparam logic [3:0] OP_NEXT_DIE    = 4'd6;
	localparam logic [3:0] OP_READ_TARGET = 4'd7;
	localparam logic [3:0] OP_RESULT      = 4'd8;

	// branch conditions
	localparam logic [2:0] COND_NEVER    = 3'd0;
	localparam logic [2:0] COND_NO_INPUT = 3'd1;
	localparam logic [2:0] COND_DIE_DONE = 3'd2;
	localparam logic [2:0] COND_T_DONE   = 3'd3;
	localparam logic [2:0] COND_J_DONE   = 3'd4;
	localparam logic [2:0] COND_OUT_BUSY = 3'd5;

	// program steps
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] PC_IDLE       = 3'd0;
	localparam logic [PC_W-1:0] PC_DIE_TEST   = 3'd1;
	localparam logic [PC_W-1:0] PC_T_TEST     = 3'd2;
	localparam logic [PC_W-1:0] PC_J_TEST     = 3'd3;
	localparam logic [PC_W-1:0] PC_WRITE      = 3'd4;
	localparam logic [PC_W-1:0] PC_NEXT_DIE   = 3'd5;
	localparam logic [PC_W-1:0] PC_FINAL_READ = 3'd6;
	localparam logic [PC_W-1:0] PC_RESULT     = 3'd7;

	// when cond holds: go to br, op suppressed; otherwise run op and go to nx
	typedef struct packed {
		logic [3:0]      op;
		logic [2:0]      cond;
		logic [PC_W-1:0] br;
		logic [PC_W-1:0] nx;
	} ctrl_word_t;

	typedef struct packed {
		logic die_done;
		logic t_done;
		logic j_done;
	} status_t;

	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			PC_IDLE:       w = '{OP_LOAD,        COND_NO_INPUT, PC_IDLE,       PC_DIE_TEST};
			PC_DIE_TEST:   w = '{OP_ROW_START,   COND_DIE_DONE, PC_FINAL_READ, PC_T_TEST};
			PC_T_TEST:     w = '{OP_SUM_START,   COND_T_DONE,   PC_NEXT_DIE,   PC_J_TEST};
			PC_J_TEST:     w = '{OP_READ_TAP,    COND_J_DONE,   PC_WRITE,      PC_J_TEST};
			PC_WRITE:      w = '{OP_WRITE,       COND_NEVER,    PC_IDLE,       PC_T_TEST};
			PC_NEXT_DIE:   w = '{OP_NEXT_DIE,    COND_NEVER,    PC_IDLE,       PC_DIE_TEST};
			PC_FINAL_READ: w = '{OP_READ_TARGET, COND_NEVER,    PC_IDLE,       PC_RESULT};
			PC_RESULT:     w = '{OP_RESULT,      COND_OUT_BUSY, PC_RESULT,     PC_IDLE};
			default:       w = '{OP_NONE,        COND_NEVER,    PC_IDLE,       PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

### sv/dice_sum_ways_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dice_sum_ways_counter: ordered dice sequences with a given total
// Counts ways for n dice with faces 1..k to sum to a target, mod 1000000007.
// ----------------------------------------------------------------------------
// usage
//  s_* channel takes one request: dice count, face count, target sum
//  m_* channel returns one way count per request, in request order
//  a microcode sequencer walks a table of partial counts: for every die and
//  every sum 1..T it reads up to k entries of the previous row, one memory
//  read per cycle, and writes the new entry
//  the run time is set by the single read port of the row memories; a target
//  above 1024 skips the die loop and answers zero; the next request is taken
//  once the sequencer is back at its idle step
//  one request is worked at a time; s_tready is high only while idle
//  the result sits in an output register, so the next request is taken
//  while that result waits; a stalled receiver holds a finished result
//  only at the final handoff step
//  reset clears the sequencer and the output valid; no memory sweep needed
// ----------------------------------------------------------------------------
module dice_sum_ways_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // dice_count[5:0], face_count[11:6], target_sum[22:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // way_count[29:0]
);

	logic [dsw_pkg::PC_W-1:0]  pc_q;
	dsw_pkg::ctrl_word_t       cw;
	dsw_pkg::status_t          status;
	logic                      cond_hit;
	logic [3:0]                dp_op;
	logic [dsw_pkg::WAY_W-1:0] final_way;
	logic [dsw_pkg::WAY_W-1:0] way_q;
	logic                      m_tvalid_q;

	assign cw = dsw_pkg::ucode_rom(pc_q);

	always_comb begin
		case (cw.cond)
			dsw_pkg::COND_NEVER:    cond_hit = 1'b0;
			dsw_pkg::COND_NO_INPUT: cond_hit = !s_tvalid;
			dsw_pkg::COND_DIE_DONE: cond_hit = status.die_done;
			dsw_pkg::COND_T_DONE:   cond_hit = status.t_done;
			dsw_pkg::COND_J_DONE:   cond_hit = status.j_done;
			dsw_pkg::COND_OUT_BUSY: cond_hit = m_tvalid_q && !m_tready;
			default:                cond_hit = 1'b0;
		endcase
	end

	assign dp_op    = cond_hit ? dsw_pkg::OP_NONE : cw.op;
	assign s_tready = pc_q == dsw_pkg::PC_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, way_q};

	dsw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (dp_op),
		.dice_count (s_tdata[5:0]),
		.face_count (s_tdata[11:6]),
		.target_sum (s_tdata[22:12]),
		.status     (status),
		.final_way  (final_way)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= dsw_pkg::PC_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			pc_q <= cond_hit ? cw.br : cw.nx;
			if (dp_op == dsw_pkg::OP_RESULT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_op == dsw_pkg::OP_RESULT) begin
			way_q <= final_way;
		end
	end

	// an accepted request always starts the die loop next
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> pc_q == dsw_pkg::PC_DIE_TEST)
		else $error("request accepted but sequencer did not start");

	// a new result only appears from the result step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(pc_q) == dsw_pkg::PC_RESULT)
		else $error("result valid raised outside result step");

	// the count is always reduced
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[29:0]} < dsw_pkg::WAY_MOD)
		else $error("way count not reduced");

endmodule

### sv/dsw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsw_datapath: row memories, counters and modular accumulator
// Two ping-pong rows of partial counts; one read or one write per cycle.
// ----------------------------------------------------------------------------
module dsw_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [3:0]                       op,
	input  logic [dsw_pkg::COUNT_W-1:0]      dice_count,
	input  logic [dsw_pkg::COUNT_W-1:0]      face_count,
	input  logic [dsw_pkg::SUM_W-1:0]        target_sum,
	output dsw_pkg::status_t                 status,
	output logic [dsw_pkg::WAY_W-1:0]        final_way
);

	logic [dsw_pkg::WAY_W-1:0] row0_mem [0:dsw_pkg::ROW_DEPTH-1];
	logic [dsw_pkg::WAY_W-1:0] row1_mem [0:dsw_pkg::ROW_DEPTH-1];

	logic [dsw_pkg::COUNT_W-1:0] n_q, k_q, die_q, j_q;
	logic [dsw_pkg::SUM_W-1:0]   tgt_q, t_q;
	logic                        big_q;
	logic                        rd_pend_q;
	logic [dsw_pkg::WAY_W-1:0]   acc_q;

	logic [dsw_pkg::WAY_W-1:0]   rd0_q, rd1_q;
	logic                        rpar_q, rvirt_q, rzero_q;

	logic                        rd_en, wr_en;
	logic [dsw_pkg::SUM_W-1:0]   raddr, waddr, j_ext;
	logic [dsw_pkg::WAY_W-1:0]   wdata, rdata_v, acc_next;
	logic [dsw_pkg::WAY_W:0]     sum_raw;

	assign j_ext = {{(dsw_pkg::SUM_W-dsw_pkg::COUNT_W){1'b0}}, j_q};

	assign rd_en = (op == dsw_pkg::OP_READ_TAP) || (op == dsw_pkg::OP_READ_TARGET);
	assign raddr = (op == dsw_pkg::OP_READ_TAP) ? (t_q - j_ext) :
		(big_q ? '0 : tgt_q);

	assign wr_en = (op == dsw_pkg::OP_ROW_START) || (op == dsw_pkg::OP_WRITE);
	assign waddr = (op == dsw_pkg::OP_WRITE) ? t_q : '0;
	assign wdata = (op == dsw_pkg::OP_WRITE) ? acc_q : '0;

	// row zero is never stored: it reads as one at sum zero and zero elsewhere
	assign rdata_v = rvirt_q ? {{(dsw_pkg::WAY_W-1){1'b0}}, rzero_q} :
		(rpar_q ? rd1_q : rd0_q);

	assign sum_raw  = {1'b0, acc_q} + {1'b0, rdata_v};
	assign acc_next = (sum_raw >= dsw_pkg::WAY_MOD) ?
		dsw_pkg::WAY_W'(sum_raw - dsw_pkg::WAY_MOD) : sum_raw[dsw_pkg::WAY_W-1:0];

	assign final_way = big_q ? '0 : rdata_v;

	assign status.die_done = big_q || (die_q > n_q);
	assign status.t_done   = t_q > tgt_q;
	assign status.j_done   = (j_q > k_q) || (j_ext > t_q);

	// row memories: write row of the current die, read row of the previous die
	always_ff @(posedge clk) begin
		if (wr_en && !die_q[0]) begin
			row0_mem[waddr] <= wdata;
		end
		if (wr_en && die_q[0]) begin
			row1_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd0_q   <= row0_mem[raddr];
			rd1_q   <= row1_mem[raddr];
			rpar_q  <= ~die_q[0];
			rvirt_q <= die_q == dsw_pkg::COUNT_W'(1);
			rzero_q <= raddr == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == dsw_pkg::OP_LOAD) begin
			n_q   <= (dice_count > dsw_pkg::COUNT_W'(dsw_pkg::MAX_DICE)) ?
				dsw_pkg::COUNT_W'(dsw_pkg::MAX_DICE) : dice_count;
			k_q   <= (face_count > dsw_pkg::COUNT_W'(dsw_pkg::MAX_FACES)) ?
				dsw_pkg::COUNT_W'(dsw_pkg::MAX_FACES) : face_count;
			tgt_q <= target_sum;
		end
		if (op == dsw_pkg::OP_SUM_START) begin
			acc_q <= '0;
		end else if (rd_pend_q) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			die_q     <= '0;
			t_q       <= '0;
			j_q       <= '0;
			big_q     <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= op == dsw_pkg::OP_READ_TAP;
			case (op)
				dsw_pkg::OP_LOAD: begin
					die_q <= dsw_pkg::COUNT_W'(1);
					big_q <= target_sum > dsw_pkg::SUM_W'(dsw_pkg::MAX_SUM);
				end
				dsw_pkg::OP_ROW_START: t_q   <= dsw_pkg::SUM_W'(1);
				dsw_pkg::OP_SUM_START: j_q   <= dsw_pkg::COUNT_W'(1);
				dsw_pkg::OP_READ_TAP:  j_q   <= j_q + 1'b1;
				dsw_pkg::OP_WRITE:     t_q   <= t_q + 1'b1;
				dsw_pkg::OP_NEXT_DIE:  die_q <= die_q + 1'b1;
				default: ;
			endcase
		end
	end

endmodule
